// File: hw/rtl/rbcf_pkg.sv
// ----------------------------------------------------------------------------
// rbcf_pkg
// Shared widths, codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package rbcf_pkg;

  localparam int IMG_W_W   = 13;
  localparam int HEIGHT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINTABLE_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RASTER_MODE     = 3'd4;

  // GS v 0 header bytes
  localparam logic [7:0] HDR_GS   = 8'h1D;
  localparam logic [7:0] HDR_V    = 8'h76;
  localparam logic [7:0] HDR_ZERO = 8'h30;
  localparam logic [7:0] HDR_MODE = 8'h00;

  // header byte positions
  localparam logic [3:0] HB_GS       = 4'd0;
  localparam logic [3:0] HB_V        = 4'd1;
  localparam logic [3:0] HB_ZERO     = 4'd2;
  localparam logic [3:0] HB_MODE     = 4'd3;
  localparam logic [3:0] HB_STRIDE_L = 4'd4;
  localparam logic [3:0] HB_STRIDE_H = 4'd5;
  localparam logic [3:0] HB_ROWS_L   = 4'd6;
  localparam logic [3:0] HB_ROWS_H   = 4'd7;
  localparam logic [3:0] HB_DATA     = 4'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic        err;
    logic        hdr;
    logic [15:0] stride;
    logic [15:0] rows;
    logic        data_v;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

endpackage

// File: hw/rtl/rbcf_front.sv
// ----------------------------------------------------------------------------
// rbcf_front
// Tracks the raster position, clips and masks source bytes, and turns each
// source byte into at most one command word for the back end.
// ----------------------------------------------------------------------------
module rbcf_front #(
  parameter int MAX_WIDTH_DOTS = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rbcf_pkg::IMG_W_W-1:0] image_width_i,
  input  logic [rbcf_pkg::HEIGHT_W-1:0] image_height_i,
  input  logic [rbcf_pkg::IMG_W_W-1:0] printable_width_i,
  input  logic [rbcf_pkg::HEIGHT_W-1:0] band_height_i,
  input  logic                         raster_mode_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   source_byte_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output rbcf_pkg::cmd_t               q_cmd_o
);
  import rbcf_pkg::*;

  localparam int ImgMax    = (1 << IMG_W_W) - 1;
  localparam int SatMax    = (MAX_WIDTH_DOTS < ImgMax) ? MAX_WIDTH_DOTS : ImgMax;
  localparam int StrideMax = (SatMax + 7) / 8;
  localparam int ColW      = (StrideMax > 2) ? $clog2(StrideMax) : 1;
  localparam int StrW      = IMG_W_W - 2;
  localparam logic [IMG_W_W-1:0] SatMaxC = IMG_W_W'(SatMax);

  logic [ColW-1:0]     col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;
  logic [HEIGHT_W-1:0] brl_q, brl_d;
  logic                jf_q, jf_d;

  logic [IMG_W_W-1:0]  img_w, w;
  logic [IMG_W_W:0]    img_w_r, w_r;
  logic [StrW-1:0]     src_stride, out_stride, col_x, col_inc;
  logic [2:0]          used;
  logic [7:0]          last_mask;
  logic                restart;
  logic [ColW-1:0]     col;
  logic [HEIGHT_W-1:0] row, brl, brl1, band, remain, rows;
  logic [HEIGHT_W:0]   row_inc;
  logic                jf, err_now, jf1, hdr, data_v, row_end, accept;

  always_comb begin
    img_w   = (image_width_i > SatMaxC) ? SatMaxC : image_width_i;
    w       = (printable_width_i < img_w) ? printable_width_i : img_w;
    img_w_r = {1'b0, img_w} + (IMG_W_W+1)'(7);
    w_r     = {1'b0, w} + (IMG_W_W+1)'(7);
    src_stride = img_w_r[IMG_W_W:3];
    out_stride = w_r[IMG_W_W:3];
    used       = w[2:0];
    last_mask  = ((w < img_w) && (used != 3'd0)) ?
                 8'(8'hFF << (4'd8 - {1'b0, used})) : 8'hFF;

    // a config change can leave the row past the image: start a new job
    restart = (row_q >= image_height_i);
    col = restart ? '0 : col_q;
    row = restart ? '0 : row_q;
    brl = restart ? '0 : brl_q;
    jf  = restart ? 1'b0 : jf_q;

    col_x   = StrW'(col);
    col_inc = col_x + StrW'(1);
    row_inc = {1'b0, row} + (HEIGHT_W+1)'(1);

    err_now = (row == '0) && (col == '0) && !jf &&
              (raster_mode_i || (w == '0) || (image_height_i == '0));
    jf1     = jf | err_now;

    band   = (band_height_i == '0) ? HEIGHT_W'(1) : band_height_i;
    remain = image_height_i - row;
    rows   = (band < remain) ? band : remain;
    hdr    = !jf1 && (col == '0) && (brl == '0);
    brl1   = hdr ? rows : brl;

    data_v  = !jf1 && (col_x < out_stride);
    row_end = (col_inc == out_stride);

    q_cmd_o.err    = err_now;
    q_cmd_o.hdr    = hdr;
    q_cmd_o.stride = 16'(out_stride);
    q_cmd_o.rows   = rows;
    q_cmd_o.data_v = data_v;
    q_cmd_o.data   = row_end ? (source_byte_i & last_mask) : source_byte_i;
    q_cmd_o.last   = err_now || (row_end && (row_inc == {1'b0, image_height_i}));

    accept     = in_valid_i && !q_full_i;
    in_stall_o = q_full_i;
    q_push_o   = accept && (err_now || hdr || data_v);

    // advance the source position
    col_d = col_q;
    row_d = row_q;
    brl_d = brl_q;
    jf_d  = jf_q;
    if (accept) begin
      if (col_inc >= src_stride) begin
        if (row_inc >= {1'b0, image_height_i}) begin
          col_d = '0;
          row_d = '0;
          brl_d = '0;
          jf_d  = 1'b0;
        end else begin
          col_d = '0;
          row_d = row_inc[HEIGHT_W-1:0];
          brl_d = (brl1 != '0) ? brl1 - HEIGHT_W'(1) : brl1;
          jf_d  = jf1;
        end
      end else begin
        col_d = col_inc[ColW-1:0];
        row_d = row;
        brl_d = brl1;
        jf_d  = jf1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      brl_q <= '0;
      jf_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      brl_q <= brl_d;
      jf_q  <= jf_d;
    end
  end

endmodule

// File: hw/rtl/rbcf_fifo.sv
// ----------------------------------------------------------------------------
// rbcf_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module rbcf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rbcf_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rbcf_pkg::cmd_t cmd_o
);
  import rbcf_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QUEUE_PTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    full_o  = (cnt_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    valid_o = (cnt_q != '0);
    cmd_o   = mem_q[rp_q];
    wp_d    = push_i ? wp_q + QUEUE_PTR_W'(1) : wp_q;
    rp_d    = pop_i ? rp_q + QUEUE_PTR_W'(1) : rp_q;
    cnt_d   = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QUEUE_PTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QUEUE_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/rbcf_back.sv
// ----------------------------------------------------------------------------
// rbcf_back
// Expands command words into output bytes: error word, band header, data.
// Holds the registered output word.
// ----------------------------------------------------------------------------
module rbcf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  rbcf_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           last_o,
  output logic           error_o
);
  import rbcf_pkg::*;

  logic [3:0] step_q, step_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;
  logic       oerr_q, oerr_d;
  logic       out_ready, fire, done;
  logic [7:0] hbyte;

  always_comb begin
    case (step_q)
      HB_GS:       hbyte = HDR_GS;
      HB_V:        hbyte = HDR_V;
      HB_ZERO:     hbyte = HDR_ZERO;
      HB_MODE:     hbyte = HDR_MODE;
      HB_STRIDE_L: hbyte = q_cmd_i.stride[7:0];
      HB_STRIDE_H: hbyte = q_cmd_i.stride[15:8];
      HB_ROWS_L:   hbyte = q_cmd_i.rows[7:0];
      HB_ROWS_H:   hbyte = q_cmd_i.rows[15:8];
      default:     hbyte = q_cmd_i.data;
    endcase

    out_ready = !ovalid_q || !out_stall_i;
    fire      = q_valid_i && out_ready;

    obyte_d = obyte_q;
    olast_d = olast_q;
    oerr_d  = oerr_q;
    done    = 1'b1;
    if (q_cmd_i.err) begin
      obyte_d = 8'h00;
      olast_d = 1'b1;
      oerr_d  = 1'b1;
    end else if (q_cmd_i.hdr && (step_q != HB_DATA)) begin
      obyte_d = hbyte;
      olast_d = 1'b0;
      oerr_d  = 1'b0;
      done    = (step_q == HB_ROWS_H) && !q_cmd_i.data_v;
    end else begin
      obyte_d = q_cmd_i.data;
      olast_d = q_cmd_i.last;
      oerr_d  = 1'b0;
    end

    q_pop_o  = fire && done;
    step_d   = fire ? (done ? HB_GS : step_q + 4'd1) : step_q;
    ovalid_d = fire ? 1'b1 : (out_ready ? 1'b0 : ovalid_q);

    out_valid_o = ovalid_q;
    out_byte_o  = obyte_q;
    last_o      = olast_q;
    error_o     = oerr_q;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obyte_q <= obyte_d;
      olast_q <= olast_d;
      oerr_q  <= oerr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= HB_GS;
      ovalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// File: hw/rtl/raster_band_command_framer.sv
// A source word's first result goes through the command queue, then the output
// register. The input takes 1 source word per cycle unless the queue is full,
// also one that yields no result; each band start adds 8 header words, and the
// back end's single output port (1 word per cycle unless stalled) sets the pace.
// Reset: asynchronous, active low; clears the raster position, the command
// queue and the output valid flag, and loads the register defaults.
// ----------------------------------------------------------------------------
// raster_band_command_framer
// Frames a 1 bpp bitmap into GS v 0 raster bands, clipped to the head width.
// ----------------------------------------------------------------------------
module raster_band_command_framer #(
  parameter int MAX_WIDTH_DOTS = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbcf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rbcf_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     source_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           last_o,
  output logic                           error_o
);
  import rbcf_pkg::*;

  logic [IMG_W_W-1:0]  image_width_q;
  logic [HEIGHT_W-1:0] image_height_q;
  logic [IMG_W_W-1:0]  printable_width_q;
  logic [HEIGHT_W-1:0] band_height_q;
  logic                raster_mode_q;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q     <= IMG_W_W'(384);
      image_height_q    <= HEIGHT_W'(1);
      printable_width_q <= IMG_W_W'(384);
      band_height_q     <= HEIGHT_W'(24);
      raster_mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:     image_width_q     <= cfg_wdata_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:    image_height_q    <= cfg_wdata_i[HEIGHT_W-1:0];
        CFG_PRINTABLE_WIDTH: printable_width_q <= cfg_wdata_i[IMG_W_W-1:0];
        CFG_BAND_HEIGHT:     band_height_q     <= cfg_wdata_i[HEIGHT_W-1:0];
        CFG_RASTER_MODE:     raster_mode_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  rbcf_front #(
    .MAX_WIDTH_DOTS(MAX_WIDTH_DOTS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .image_width_i    (image_width_q),
    .image_height_i   (image_height_q),
    .printable_width_i(printable_width_q),
    .band_height_i    (band_height_q),
    .raster_mode_i    (raster_mode_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .source_byte_i    (source_byte_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (push_cmd)
  );

  rbcf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  rbcf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (head_cmd),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

endmodule

// File: hw/rtl/rbcf_checker.sv
// ----------------------------------------------------------------------------
// rbcf_checker
// Port-level checks on the framer's output stream.
// ----------------------------------------------------------------------------
module rbcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic       error_o
);

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(out_byte_o) && $stable(last_o) && $stable(error_o))
    else $error("output word changed while stalled");

  // a rejected job is a single closing word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o)
    else $error("error word without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> out_byte_o == 8'h00)
    else $error("error word carries data");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind raster_band_command_framer rbcf_checker u_rbcf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o),
  .last_o     (last_o),
  .error_o    (error_o)
);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bitmap bytes into raster_band_command_framer under several register
// settings and checks every emitted command word against a band framing
// predictor: headers, clipping, tail masking, last flags and rejected jobs.
// ----------------------------------------------------------------------------
module testbench;
  import rbcf_pkg::*;

  localparam int MAX_WIDTH_DOTS = 4096;
  localparam int ITEM_TARGET    = 470;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  // index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } framer_word_t;

  class band_stream_checker;
    logic [IMG_W_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [IMG_W_W-1:0]  head_width_reg;
    logic [HEIGHT_W-1:0] band_reg;
    logic                mode_reg;
    int unsigned         col_pos;
    int unsigned         row_pos;
    int unsigned         rows_left_in_band;
    bit                  job_rejected;
    framer_word_t        pending_words[$];
    int                  errors;
    int                  words_taken;

    function new();
      width_reg      = 13'd384;
      height_reg     = 16'd1;
      head_width_reg = 13'd384;
      band_reg       = 16'd24;
      mode_reg       = 1'b0;
      errors         = 0;
      words_taken    = 0;
      restart_job();
    endfunction

    function void restart_job();
      col_pos           = 0;
      row_pos           = 0;
      rows_left_in_band = 0;
      job_rejected      = 1'b0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:     width_reg      = data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:    height_reg     = data[HEIGHT_W-1:0];
        CFG_PRINTABLE_WIDTH: head_width_reg = data[IMG_W_W-1:0];
        CFG_BAND_HEIGHT:     band_reg       = data[HEIGHT_W-1:0];
        CFG_RASTER_MODE:     mode_reg       = data[0];
        default: ;
      endcase
    endfunction

    function void push_word(logic [7:0] data, logic last, logic err);
      framer_word_t w;
      w.data = data;
      w.last = last;
      w.err  = err;
      pending_words.insert(pending_words.size(), w);
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // called for every accepted source byte
    function void predict_words(logic [7:0] src);
      int unsigned src_w, clip_w, src_stride, out_stride, tail_bits, band, rows;
      logic [7:0]  tail_mask;
      bit          row_end;
      src_w       = (width_reg > MAX_WIDTH_DOTS) ? MAX_WIDTH_DOTS : width_reg;
      clip_w      = (head_width_reg < src_w) ? head_width_reg : src_w;
      src_stride  = (src_w + 7) / 8;
      out_stride  = (clip_w + 7) / 8;
      tail_bits   = clip_w % 8;
      tail_mask   = (clip_w < src_w && tail_bits != 0) ? 8'hFF << (8 - tail_bits) : 8'hFF;

      if (row_pos >= height_reg) restart_job();

      if (row_pos == 0 && col_pos == 0 && !job_rejected &&
          (mode_reg || clip_w == 0 || height_reg == 0)) begin
        job_rejected = 1'b1;
        push_word(8'h00, 1'b1, 1'b1);
      end

      if (!job_rejected) begin
        if (col_pos == 0 && rows_left_in_band == 0) begin
          band = (band_reg == 0) ? 1 : band_reg;
          rows = height_reg - row_pos;
          if (band < rows) rows = band;
          push_word(HDR_GS, 1'b0, 1'b0);
          push_word(HDR_V, 1'b0, 1'b0);
          push_word(HDR_ZERO, 1'b0, 1'b0);
          push_word(HDR_MODE, 1'b0, 1'b0);
          push_word(out_stride[7:0], 1'b0, 1'b0);
          push_word(out_stride[15:8], 1'b0, 1'b0);
          push_word(rows[7:0], 1'b0, 1'b0);
          push_word(rows[15:8], 1'b0, 1'b0);
          rows_left_in_band = rows;
        end
        if (col_pos < out_stride) begin
          row_end = (col_pos + 1 == out_stride);
          push_word(row_end ? (src & tail_mask) : src,
                    row_end && (row_pos + 1 == height_reg), 1'b0);
        end
      end

      // step the source position; a column at or past the stride ends the row
      if (col_pos + 1 >= src_stride) begin
        col_pos = 0;
        if (rows_left_in_band > 0) rows_left_in_band--;
        row_pos++;
        if (row_pos >= height_reg) restart_job();
      end else begin
        col_pos++;
      end

      words_taken++;
    endfunction

    function void check_word(logic [7:0] data, logic last, logic err);
      framer_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h last %b error %b",
                 $time, data, last, err);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, last);
        errors++;
      end
      if (err !== want.err) begin
        $display("%0t: error expected %b actual %b", $time, want.err, err);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  logic                 src_valid;
  logic                 src_stall;
  logic [7:0]           source_byte;
  logic                 word_valid;
  logic                 word_stall;
  logic [7:0]           out_byte;
  logic                 word_last;
  logic                 word_error;
  bit                   no_gaps;

  band_stream_checker board;

  raster_band_command_framer #(
    .MAX_WIDTH_DOTS(MAX_WIDTH_DOTS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (src_valid),
    .in_stall_o   (src_stall),
    .source_byte_i(source_byte),
    .out_valid_o  (word_valid),
    .out_stall_i  (word_stall),
    .out_byte_o   (out_byte),
    .last_o       (word_last),
    .error_o      (word_error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (src_valid && !src_stall) board.predict_words(source_byte);
      if (word_valid && !word_stall) board.check_word(out_byte, word_last, word_error);
    end
  end

  // receiver back-pressure: free runs alternate with stalls, mostly short
  initial begin : receiver_stall
    int run, hold, r;
    word_stall = 1'b0;
    forever begin
      r    = $urandom_range(0, 99);
      run  = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      r    = $urandom_range(0, 99);
      hold = (r < 85) ? $urandom_range(1, 3) : (r < 97) ? $urandom_range(4, 10)
                                                       : $urandom_range(20, 40);
      @(negedge clk);
      word_stall <= 1'b0;
      repeat (run - 1) @(negedge clk);
      @(negedge clk);
      word_stall <= 1'b1;
      repeat (hold - 1) @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((src_valid && !src_stall) || (word_valid && !word_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("raster_band_command_framer test failed");
    $finish;
  end

  function automatic int source_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // valid stays high across back-to-back words; this task lowers it only for a gap
  task automatic send_source(input logic [7:0] value);
    int gap;
    gap = source_gap();
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid   <= 1'b1;
    source_byte <= value;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // idle point for register writes: no result owed and the pipe has emptied
  task automatic quiesce();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  // bits above a register's width are random and must be dropped
  task automatic write_config(input int width, input int height, input int head,
                              input int band, input int mode);
    write_reg(CFG_IMAGE_WIDTH, {3'($urandom), 13'(width)});
    write_reg(CFG_IMAGE_HEIGHT, 16'(height));
    write_reg(CFG_PRINTABLE_WIDTH, {3'($urandom), 13'(head)});
    write_reg(CFG_BAND_HEIGHT, 16'(band));
    write_reg(CFG_RASTER_MODE, {15'($urandom), 1'(mode)});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] tail_pattern [6];
    int         pick, width, height, head, band, count, drain_at, phase;
    bit         wide_full_done;

    tail_pattern = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h7F};
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IMAGE_WIDTH;
    cfg_wdata   = '0;
    src_valid   = 1'b0;
    source_byte = 8'h00;
    no_gaps     = 1'b0;
    board       = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // clipped to 10 of 12 dots: tail masked, 3 rows in bands of 2
    write_config(12, 3, 10, 2, 0);
    foreach (tail_pattern[i]) send_source(tail_pattern[i]);
    // unsupported raster mode
    quiesce();
    write_config(8, 2, 8, 1, 1);
    send_source(8'hA5);
    send_source(8'h5A);
    // zero print head width
    quiesce();
    write_config(16, 1, 0, 24, 0);
    send_source(8'hFF);
    send_source(8'h01);
    // image width above the maximum saturates; left mid-row on purpose
    quiesce();
    write_config(8191, 1, 8191, 65535, 0);
    repeat (6) send_source(8'($urandom));
    // zero image height
    quiesce();
    write_config(8, 0, 8, 1, 0);
    send_source(8'h00);
    send_source(8'hFF);
    // band height zero acts as one
    quiesce();
    write_config(1, 2, 8, 0, 0);
    send_source(8'h80);
    send_source(8'hFF);
    // tallest image and band
    quiesce();
    write_config(1, 65535, 1, 65535, 0);
    send_source(8'hFF);
    send_source(8'h00);
    // zero image width, plus a write to an unused index
    quiesce();
    write_config(0, 1, 4096, 24, 0);
    write_reg(CFG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    send_source(8'hC3);

    wide_full_done = 1'b0;
    phase          = 0;
    while (board.words_taken < ITEM_TARGET) begin
      quiesce();
      no_gaps = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 6) begin
        width  = $urandom_range(1, 64);
        height = $urandom_range(1, 4);
        band   = $urandom_range(0, 4);
        case ($urandom_range(0, 2))
          0:       write_config(width, height, width, band, 1);
          1:       write_config(width, height, 0, band, 0);
          default: write_config(width, 0, width, band, 0);
        endcase
        count = $urandom_range(1, 4);
      end else if (pick < 10) begin
        // wide source rows, mostly cut short
        width = $urandom_range(4000, 8191);
        head  = $urandom_range(1, 200);
        band  = $urandom_range(0, 3);
        if (!wide_full_done) begin
          write_config(width, 1, head, band, 0);
          count          = (((width > MAX_WIDTH_DOTS) ? MAX_WIDTH_DOTS : width) + 7) / 8;
          wide_full_done = 1'b1;
        end else begin
          write_config(width, $urandom_range(1, 3), head, band, 0);
          count = $urandom_range(4, 30);
        end
      end else begin
        width  = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 64);
        height = $urandom_range(1, 6);
        head   = $urandom_range(0, 1) ? $urandom_range(width, 4096) : $urandom_range(1, width);
        pick   = $urandom_range(0, 19);
        band   = (pick == 0) ? 65535 : (pick == 1) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 4);
        write_config(width, height, head, band, 0);
        count = ((width + 7) / 8) * height;
        // broken jobs: cut short or run over into the next image
        pick = $urandom_range(0, 19);
        if (pick == 0) count = $urandom_range(1, count);
        else if (pick == 1) count += $urandom_range(1, 4);
      end
      drain_at = (phase == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : -1;
      for (int i = 0; i < count; i++) begin
        if (i == drain_at) drain();
        send_source(($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom));
      end
      phase++;
    end

    quiesce();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("raster_band_command_framer test passed");
    end else begin
      $display("raster_band_command_framer test failed");
    end
    $finish;
  end

endmodule
